FILE: sv/swdbd_pkg.sv
// ----------------------------------------------------------------------------
// swdbd_pkg
// shared constants, types and state codes of the sliding window distinct
// byte detector
// ----------------------------------------------------------------------------
package swdbd_pkg;

    localparam int WINDOW      = 64;
    localparam int OFFSET_BITS = 32;
    localparam int COUNT_DEPTH = 256;

    localparam int BYTE_W    = 8;
    localparam int PTR_W     = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = $clog2(WINDOW * 255 + 1);
    localparam int WSUM_W    = $clog2((WINDOW * (WINDOW + 1) / 2) * 255 + 1);
    localparam int THR_W     = 7;
    localparam int CMP_W     = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam int START_OUT_W = 32;
    localparam int DIST_OUT_W  = 7;
    localparam int SUM_OUT_W   = 14;
    localparam int WSUM_OUT_W  = 20;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(52);

    localparam logic REG_IDX_THRESHOLD = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CALC  = 3'b010,
        ST_WRITE = 3'b100
    } swdbd_state_t;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic [BYTE_W-1:0] addr_a;
        logic [BYTE_W-1:0] addr_b;
    } swdbd_cnt_rd_t;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } swdbd_cnt_wr_t;

    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } swdbd_win_wr_t;

endpackage

FILE: sv/swdbd_count_store.sv
// ----------------------------------------------------------------------------
// swdbd_count_store
// per byte value occurrence counts: two read ports, one write port, valid
// bits for clearing all counts at once and forwarding of a same-edge write
// ----------------------------------------------------------------------------
module swdbd_count_store
    import swdbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swdbd_cnt_rd_t        rd,
    input  swdbd_cnt_wr_t        wr,
    output logic [CNT_W-1:0]     cnt_a,
    output logic [CNT_W-1:0]     cnt_b
);

    logic [CNT_W-1:0]       mem [COUNT_DEPTH];
    logic [COUNT_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]       rd_a_reg;
    logic [CNT_W-1:0]       rd_b_reg;
    logic                   live_a_reg;
    logic                   live_b_reg;
    logic                   fwd_a_reg;
    logic                   fwd_b_reg;
    logic [CNT_W-1:0]       fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_a_reg     <= mem[rd.addr_a];
            rd_b_reg     <= mem[rd.addr_b];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            live_a_reg <= 1'b0;
            live_b_reg <= 1'b0;
            fwd_a_reg  <= 1'b0;
            fwd_b_reg  <= 1'b0;
        end
        else
        begin
            if (rd.en && rd.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                live_a_reg <= valid_reg[rd.addr_a] && !rd.clear;
                live_b_reg <= valid_reg[rd.addr_b] && !rd.clear;
                fwd_a_reg  <= wr.en && !rd.clear && (wr.addr == rd.addr_a);
                fwd_b_reg  <= wr.en && !rd.clear && (wr.addr == rd.addr_b);
            end
        end
    end

    // write on the read edge wins over the stale array data
    assign cnt_a = fwd_a_reg ? fwd_data_reg : (live_a_reg ? rd_a_reg : '0);
    assign cnt_b = fwd_b_reg ? fwd_data_reg : (live_b_reg ? rd_b_reg : '0);

endmodule

FILE: sv/swdbd_window_store.sv
// ----------------------------------------------------------------------------
// swdbd_window_store
// ring of the last window bytes with a registered read of the slot that is
// overwritten next
// ----------------------------------------------------------------------------
module swdbd_window_store
    import swdbd_pkg::*;
(
    input  logic                 clk,
    input  swdbd_win_wr_t        wr,
    input  logic [PTR_W-1:0]     rd_addr,
    output logic [BYTE_W-1:0]    old_byte
);

    logic [BYTE_W-1:0] mem [WINDOW];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign old_byte = rd_data_reg;

endmodule

FILE: sv/sliding_window_distinct_byte_detector_top.sv
// ----------------------------------------------------------------------------
// sliding_window_distinct_byte_detector_top
// result: registered as calc ends for its byte transaction; calc waits while
//   a held result is stalled. a new byte is taken in idle or write, not calc,
//   as the old count down and new count up share the count memory write port
// reset: asynchronous, threshold back to 52, count valid bits and all running
//   state cleared at once, no clearing pass
// ----------------------------------------------------------------------------
module sliding_window_distinct_byte_detector_top
    import swdbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [BYTE_W-1:0]       data_byte,
    input  logic                    first_of_stream,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [START_OUT_W-1:0]  window_start,
    output logic [DIST_OUT_W-1:0]   distinct_count,
    output logic [SUM_OUT_W-1:0]    byte_sum,
    output logic [WSUM_OUT_W-1:0]   weighted_sum
);

    swdbd_state_t           state_reg;
    swdbd_state_t           state_next;

    logic [THR_W-1:0]       thr_reg;
    logic [PTR_W-1:0]       wptr_reg;
    logic [PTR_W-1:0]       wptr_next;
    logic [PTR_W-1:0]       slot;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic [CNT_W-1:0]       dv_reg;
    logic [CNT_W-1:0]       dv_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [WSUM_W-1:0]      wsum_reg;
    logic [WSUM_W-1:0]      wsum_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;

    logic [BYTE_W-1:0]      b_reg;
    logic [BYTE_W-1:0]      old_reg;
    logic                   first_reg;
    logic [CNT_W-1:0]       new_cnt_reg;
    logic [CNT_W-1:0]       new_cnt_next;

    logic                   result_valid_reg;
    logic [START_OUT_W-1:0] start_reg;
    logic [DIST_OUT_W-1:0]  dist_reg;
    logic [SUM_OUT_W-1:0]   bsum_reg;
    logic [WSUM_OUT_W-1:0]  wout_reg;

    logic                   accept;
    logic                   out_free;
    logic                   calc_go;
    logic                   cfg_write;

    logic [BYTE_W-1:0]      old_byte;
    logic [CNT_W-1:0]       cnt_a;
    logic [CNT_W-1:0]       cnt_b;
    swdbd_cnt_rd_t          cnt_rd;
    swdbd_cnt_wr_t          cnt_wr;
    swdbd_win_wr_t          win_wr;

    logic                   evict;
    logic                   rm_nz;
    logic [CNT_W-1:0]       old_after;
    logic [CNT_W-1:0]       dv_mid;
    logic [CNT_W-1:0]       add_base;
    logic                   report;
    logic [CNT_W-1:0]       base_fill;
    logic [CNT_W-1:0]       base_dv;
    logic [SUM_W-1:0]       base_sum;
    logic [WSUM_W-1:0]      base_wsum;
    logic [OFFSET_BITS-1:0] base_pos;
    logic [OFFSET_BITS-1:0] start_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_IDX_THRESHOLD);

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_THRESHOLD: prdata = APB_DATA_W'(thr_reg);
            default:           prdata = '0;
        endcase
    end

    // handshake
    assign item_stall = !((state_reg == ST_IDLE) || (state_reg == ST_WRITE));
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign calc_go    = (state_reg == ST_CALC) && out_free;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  state_next = accept ? ST_CALC : ST_IDLE;
            ST_CALC:  state_next = calc_go ? ST_WRITE : ST_CALC;
            ST_WRITE: state_next = accept ? ST_CALC : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // window ring
    assign slot      = first_of_stream ? '0 : wptr_reg;
    assign wptr_next = (slot == PTR_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

    always_comb
    begin
        win_wr.en   = accept;
        win_wr.addr = slot;
        win_wr.data = data_byte;
    end

    swdbd_window_store u_window_store (
        .clk      (clk),
        .wr       (win_wr),
        .rd_addr  (wptr_reg),
        .old_byte (old_byte)
    );

    // count memory
    always_comb
    begin
        cnt_rd.en     = accept;
        cnt_rd.clear  = first_of_stream;
        cnt_rd.addr_a = data_byte;
        cnt_rd.addr_b = old_byte;
    end

    swdbd_count_store u_count_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (cnt_rd),
        .wr    (cnt_wr),
        .cnt_a (cnt_a),
        .cnt_b (cnt_b)
    );

    // update of window state
    always_comb
    begin
        base_fill = first_reg ? '0 : fill_reg;
        base_dv   = first_reg ? '0 : dv_reg;
        base_sum  = first_reg ? '0 : sum_reg;
        base_wsum = first_reg ? '0 : wsum_reg;
        base_pos  = first_reg ? '0 : pos_reg;

        evict     = (base_fill == CNT_W'(WINDOW));

        // remove the byte that leaves the window
        rm_nz     = evict && (cnt_b != '0);
        old_after = cnt_b - CNT_W'(rm_nz);
        dv_mid    = base_dv - CNT_W'(rm_nz && (old_after == '0) && (base_dv != '0));

        // add the incoming byte
        add_base     = (evict && (b_reg == old_reg)) ? old_after : cnt_a;
        new_cnt_next = add_base + 1'b1;
        dv_next      = dv_mid + CNT_W'(add_base == '0);

        if (evict)
        begin
            sum_next  = base_sum - SUM_W'(old_reg) + SUM_W'(b_reg);
            wsum_next = base_wsum - WSUM_W'(old_reg) * WSUM_W'(WINDOW)
                        + WSUM_W'(sum_next);
            fill_next = base_fill;
        end
        else
        begin
            sum_next  = base_sum + SUM_W'(b_reg);
            wsum_next = base_wsum + WSUM_W'(sum_next);
            fill_next = base_fill + 1'b1;
        end

        pos_next   = base_pos + 1'b1;
        start_next = pos_next - OFFSET_BITS'(WINDOW);
        report     = (fill_next == CNT_W'(WINDOW))
                     && (CMP_W'(dv_next) >= CMP_W'(thr_reg));
    end

    // count writes: old count down in calc, new count up in write
    always_comb
    begin
        cnt_wr = '0;
        if (calc_go && evict && (old_reg != b_reg))
        begin
            cnt_wr.en   = 1'b1;
            cnt_wr.addr = old_reg;
            cnt_wr.data = old_after;
        end
        else if (state_reg == ST_WRITE)
        begin
            cnt_wr.en   = 1'b1;
            cnt_wr.addr = b_reg;
            cnt_wr.data = new_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            thr_reg          <= THR_RESET;
            wptr_reg         <= '0;
            fill_reg         <= '0;
            dv_reg           <= '0;
            sum_reg          <= '0;
            wsum_reg         <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                thr_reg <= pwdata[THR_W-1:0];
            end
            if (accept)
            begin
                wptr_reg <= wptr_next;
            end
            if (calc_go)
            begin
                fill_reg <= fill_next;
                dv_reg   <= dv_next;
                sum_reg  <= sum_next;
                wsum_reg <= wsum_next;
                pos_reg  <= pos_next;
            end
            if (calc_go && report)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg     <= data_byte;
            old_reg   <= old_byte;
            first_reg <= first_of_stream;
        end
        if (calc_go)
        begin
            new_cnt_reg <= new_cnt_next;
        end
        if (calc_go && report)
        begin
            start_reg <= START_OUT_W'(start_next);
            dist_reg  <= DIST_OUT_W'(dv_next);
            bsum_reg  <= SUM_OUT_W'(sum_next);
            wout_reg  <= WSUM_OUT_W'(wsum_next);
        end
    end

    assign result_valid   = result_valid_reg;
    assign window_start   = start_reg;
    assign distinct_count = dist_reg;
    assign byte_sum       = bsum_reg;
    assign weighted_sum   = wout_reg;

    // checks
    a_distinct_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg <= fill_reg)
        else $error("distinct count above fill level");

    a_fill_le_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill level above window size");

    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CALC))
        else $error("accepted transaction did not enter calc");

    a_calc_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        calc_go |=> (state_reg == ST_WRITE) && cnt_wr.en)
        else $error("calc not followed by count write");

endmodule

FILE: tb/sliding_window_distinct_byte_detector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_distinct_byte_detector_top_tb
// drives byte streams into the detector and keeps its own copy of the
// 64-byte window: value tallies, distinct count, plain and weighted sums.
// each report the block makes is checked against the oldest predicted one.
// phases run the threshold through its reset value, 1, 0, 64, 65, 127 and
// random settings, with random idling on both sides, one long result hold-off
// and a watchdog on cycles with no progress.
// ----------------------------------------------------------------------------
module sliding_window_distinct_byte_detector_top_tb;
    import swdbd_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = PADDR_W'(4 * REG_IDX_THRESHOLD);

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              restart;
    } stream_byte_t;

    typedef struct packed {
        logic [START_OUT_W-1:0] start;
        logic [DIST_OUT_W-1:0]  distinct;
        logic [SUM_OUT_W-1:0]   sum;
        logic [WSUM_OUT_W-1:0]  wsum;
    } window_report_t;

    logic                   clk;
    logic                   rst_n           = 1'b0;
    logic                   psel            = 1'b0;
    logic                   penable         = 1'b0;
    logic                   pwrite          = 1'b0;
    logic [PADDR_W-1:0]     paddr           = '0;
    logic [APB_DATA_W-1:0]  pwdata          = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   item_valid      = 1'b0;
    logic                   item_stall;
    logic [BYTE_W-1:0]      data_byte       = '0;
    logic                   first_of_stream = 1'b0;
    logic                   result_valid;
    logic                   result_stall    = 1'b0;
    logic [START_OUT_W-1:0] window_start;
    logic [DIST_OUT_W-1:0]  distinct_count;
    logic [SUM_OUT_W-1:0]   byte_sum;
    logic [WSUM_OUT_W-1:0]  weighted_sum;

    // window tracker
    logic [BYTE_W-1:0]      ring [WINDOW];
    int unsigned            value_tally [COUNT_DEPTH];
    int                     ring_ptr;
    int                     bytes_held;
    int                     distinct_now;
    int unsigned            byte_total;
    int unsigned            weighted_total;
    logic [START_OUT_W-1:0] next_offset;
    logic [THR_W-1:0]       threshold_model;

    stream_byte_t           byte_queue [$];
    window_report_t         expected_reports [$];
    stream_byte_t           next_byte;
    window_report_t         want;

    int bytes_queued    = 0;
    int bytes_sent      = 0;
    int reports_seen    = 0;
    int streams_started = 1;
    int settings_used   = 0;
    int failures        = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int quiet_cycles;
    int unsigned base_value;
    int unsigned step_value;
    int unsigned span;
    logic [BYTE_W-1:0] cyc_value;

    sliding_window_distinct_byte_detector_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .data_byte       (data_byte),
        .first_of_stream (first_of_stream),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .window_start    (window_start),
        .distinct_count  (distinct_count),
        .byte_sum        (byte_sum),
        .weighted_sum    (weighted_sum)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void clear_window();
        foreach (ring[i])
            ring[i] = '0;
        foreach (value_tally[i])
            value_tally[i] = 0;
        ring_ptr       = 0;
        bytes_held     = 0;
        distinct_now   = 0;
        byte_total     = 0;
        weighted_total = 0;
        next_offset    = '0;
    endfunction

    function automatic void track_byte(input logic [BYTE_W-1:0] value, input logic restart);
        logic [BYTE_W-1:0] oldest;
        window_report_t    report;
        if (restart)
            clear_window();
        oldest = ring[ring_ptr];
        if (bytes_held < WINDOW)
            bytes_held++;
        else
        begin
            if (value_tally[oldest] != 0)
            begin
                value_tally[oldest]--;
                if (value_tally[oldest] == 0)
                    distinct_now--;
            end
            byte_total     -= oldest;
            weighted_total -= WINDOW * oldest;
        end
        if (value_tally[value] == 0)
            distinct_now++;
        value_tally[value]++;
        byte_total     += value;
        weighted_total += byte_total;
        ring[ring_ptr] = value;
        ring_ptr       = (ring_ptr + 1) % WINDOW;
        next_offset++;
        if (bytes_held >= WINDOW && distinct_now >= threshold_model)
        begin
            report.start    = next_offset - START_OUT_W'(WINDOW);
            report.distinct = DIST_OUT_W'(distinct_now);
            report.sum      = SUM_OUT_W'(byte_total);
            report.wsum     = WSUM_OUT_W'(weighted_total);
            expected_reports.push_back(report);
        end
    endfunction

    function automatic void check_field(input string field, input longint unsigned expv,
                                        input longint unsigned actv);
        if (expv != actv)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, expv, actv);
            failures++;
        end
    endfunction

    task automatic queue_byte(input int unsigned value, input bit restart);
        stream_byte_t entry;
        entry.value   = BYTE_W'(value);
        entry.restart = restart;
        byte_queue.push_back(entry);
        bytes_queued++;
        if (restart)
            streams_started++;
    endtask

    task automatic finish_phase();
        while (bytes_sent != bytes_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic read_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESHOLD_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[THR_W-1:0] !== value)
        begin
            $error("distinct_threshold readback mismatch: expected %0d, actual %0d",
                   value, prdata[THR_W-1:0]);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold_model = value;
        settings_used++;
        read_threshold(value);
    endtask

    // byte transaction driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid      <= 1'b0;
            data_byte       <= '0;
            first_of_stream <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                track_byte(data_byte, first_of_stream);
                bytes_sent++;
            end
            if (!item_valid || !item_stall)
            begin
                if (byte_queue.size() != 0 &&
                    ((bytes_sent >= 250 && bytes_sent < 330) || $urandom_range(99) >= 24))
                begin
                    next_byte = byte_queue.pop_front();
                    item_valid      <= 1'b1;
                    data_byte       <= next_byte.value;
                    first_of_stream <= next_byte.restart;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // report monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("window report with none expected: window_start %0d", window_start);
                    failures++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("window_start", want.start, window_start);
                    check_field("distinct_count", want.distinct, distinct_count);
                    check_field("byte_sum", want.sum, byte_sum);
                    check_field("weighted_sum", want.wsum, weighted_sum);
                end
                reports_seen++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && reports_seen >= 10)
            begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !(reports_seen >= 60 && reports_seen < 100) &&
                                ($urandom_range(99) < 24);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clear_window();
        threshold_model = THR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_threshold(THR_RESET);

        // short stream from reset, field extremes, then a restart
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h40, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h04, 1'b0);
        repeat (60)
            queue_byte($urandom_range(255), 1'b0);
        finish_phase();

        // single value window, largest sums
        set_threshold(THR_W'(1));
        queue_byte(8'hFF, 1'b1);
        repeat (79)
            queue_byte(8'hFF, 1'b0);
        repeat (10)
            queue_byte(8'h00, 1'b0);
        finish_phase();

        // every window reported
        set_threshold(THR_W'(0));
        queue_byte($urandom_range(3), 1'b1);
        repeat (79)
            queue_byte($urandom_range(3), 1'b0);
        finish_phase();

        // all 64 values in the window, broken now and then
        set_threshold(THR_W'(WINDOW));
        base_value = $urandom_range(255);
        step_value = 2 * $urandom_range(127) + 1;
        for (int k = 0; k < 80; k++)
        begin
            cyc_value = BYTE_W'(base_value + step_value * (k % WINDOW));
            if (k >= WINDOW && $urandom_range(19) == 0)
                cyc_value = BYTE_W'($urandom_range(255));
            queue_byte(cyc_value, k == 0);
        end
        finish_phase();

        // thresholds beyond the window
        set_threshold(THR_W'(WINDOW + 1));
        repeat (30)
            queue_byte($urandom_range(255), 1'b0);
        finish_phase();
        set_threshold(THR_W'(127));
        repeat (20)
            queue_byte($urandom_range(255), 1'b0);
        finish_phase();

        // random thresholds and value spans, rare restarts
        repeat (3)
        begin
            set_threshold(THR_W'($urandom_range(60, 45)));
            span = $urandom_range(255, 63);
            repeat (25)
                queue_byte($urandom_range(span), $urandom_range(69) == 0);
            finish_phase();
        end

        $display("covered %0d byte transactions over %0d streams, %0d window reports",
                 bytes_sent, streams_started, reports_seen);
        $display("threshold written %0d times, from 0 up to 127", settings_used);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
